FILE: design/c_lex_pkg.sv
`timescale 1ns / 1ps

package c_lex_pkg;

  localparam int unsigned TOK_W       = 24;
  localparam int unsigned KIND_W      = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DOT     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_COLON   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 4'd10;
  localparam logic [KIND_W-1:0] KIND_STAR    = 4'd11;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_END     = 4'd13;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_SLASH = 5'b00010,
    MODE_LINE  = 5'b00100,
    MODE_BLOCK = 5'b01000,
    MODE_IDENT = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  start;
    logic [TOK_W-1:0]  length;
    logic              last;
  } token_t;

  // one entry per byte that yields tokens; t1 is used only when two is set
  typedef struct packed {
    token_t t0;
    token_t t1;
    logic   two;
  } job_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] b);
    return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
    logic [KIND_W-1:0] k;
    unique case (b)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2E:   k = KIND_DOT;
      8'h2C:   k = KIND_COMMA;
      8'h3A:   k = KIND_COLON;
      8'h3B:   k = KIND_SEMI;
      8'h2A:   k = KIND_STAR;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

FILE: design/c_lex_front.sv
`timescale 1ns / 1ps

module c_lex_front #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_i,
  input  logic              full_i,
  output logic              push_o,
  output c_lex_pkg::job_t   job_o
);
  import c_lex_pkg::*;

  localparam int unsigned EXT_W = (POSITION_BITS > TOK_W) ? POSITION_BITS : TOK_W;

  mode_e                    mode_q, mode_d;
  logic                     star_q, star_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] pend_q, pend_d;

  logic              acc;
  logic              run_idle;
  logic              held_v, own_v;
  logic [KIND_W-1:0] held_kind, own_kind;
  logic [EXT_W-1:0]  held_len_ext;
  logic              own_len_one;
  logic [EXT_W-1:0]  pos_ext, pend_ext;
  token_t            held_tok, own_tok;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign pos_ext    = EXT_W'(pos_q);
  assign pend_ext   = EXT_W'(pend_q);

  always_comb begin
    mode_d       = mode_q;
    star_d       = star_q;
    pend_d       = pend_q;
    run_idle     = 1'b0;
    held_v       = 1'b0;
    held_kind    = KIND_UNKNOWN;
    held_len_ext = EXT_W'(1);
    own_v        = 1'b0;
    own_kind     = KIND_UNKNOWN;
    own_len_one  = 1'b1;

    unique case (mode_q)
      MODE_SLASH: begin
        if (data_i == CH_SLASH) begin
          mode_d = MODE_LINE;
        end else if (data_i == CH_STAR) begin
          mode_d = MODE_BLOCK;
          star_d = 1'b0;
        end else begin
          held_v   = 1'b1;
          run_idle = 1'b1;
        end
      end
      MODE_LINE: begin
        if (data_i == CH_NUL || data_i == CH_CR || data_i == CH_LF) begin
          run_idle = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (data_i == CH_NUL) begin
          run_idle = 1'b1;
        end else if (star_q && data_i == CH_SLASH) begin
          mode_d = MODE_IDLE;
          star_d = 1'b0;
        end else begin
          star_d = (data_i == CH_STAR);
        end
      end
      MODE_IDENT: begin
        if (!is_ident_tail(data_i)) begin
          held_v       = 1'b1;
          held_kind    = KIND_IDENT;
          held_len_ext = EXT_W'(pos_q - pend_q);
          run_idle     = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      mode_d = MODE_IDLE;
      if (data_i == CH_NUL) begin
        own_v       = 1'b1;
        own_kind    = KIND_END;
        own_len_one = 1'b0;
      end else if (is_blank(data_i)) begin
        own_v = 1'b0;
      end else if (data_i == CH_SLASH) begin
        mode_d = MODE_SLASH;
        pend_d = pos_q;
      end else if (is_letter(data_i)) begin
        mode_d = MODE_IDENT;
        pend_d = pos_q;
      end else begin
        own_v    = 1'b1;
        own_kind = punct_kind(data_i);
      end
    end

    // end of input puts everything back to the reset state
    if (data_i == CH_NUL) begin
      mode_d = MODE_IDLE;
      star_d = 1'b0;
      pend_d = '0;
      pos_d  = '0;
    end else if (pos_q == {POSITION_BITS{1'b1}}) begin
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + POSITION_BITS'(1);
    end
  end

  always_comb begin
    held_tok.kind   = held_kind;
    held_tok.start  = pend_ext[TOK_W-1:0];
    held_tok.length = held_len_ext[TOK_W-1:0];
    held_tok.last   = !own_v;

    own_tok.kind   = own_kind;
    own_tok.start  = pos_ext[TOK_W-1:0];
    own_tok.length = own_len_one ? TOK_W'(1) : '0;
    own_tok.last   = 1'b1;

    job_o.two = held_v && own_v;
    job_o.t0  = held_v ? held_tok : own_tok;
    job_o.t1  = own_tok;
  end

  assign push_o = acc && (held_v || own_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      star_q <= 1'b0;
      pos_q  <= '0;
      pend_q <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      star_q <= star_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
    end
  end

endmodule

FILE: design/c_lex_queue.sv
`timescale 1ns / 1ps

module c_lex_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  c_lex_pkg::job_t  job_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output c_lex_pkg::job_t  job_o
);
  import c_lex_pkg::*;

  job_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

endmodule

FILE: design/c_lex_back.sv
`timescale 1ns / 1ps

module c_lex_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  c_lex_pkg::job_t  q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output c_lex_pkg::token_t out_tok_o
);
  import c_lex_pkg::*;

  logic   out_v_q, spare_v_q;
  token_t out_q, spare_q;
  logic   out_free;

  assign out_free    = !out_v_q || out_ready_i;
  // hold the queue while the second token of a job still waits
  assign q_pop_o     = q_valid_i && out_free && !spare_v_q;
  assign out_valid_o = out_v_q;
  assign out_tok_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q && out_free) begin
      out_v_q   <= 1'b1;
      spare_v_q <= 1'b0;
    end else if (q_pop_o) begin
      out_v_q   <= 1'b1;
      spare_v_q <= q_job_i.two;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q && out_free) begin
      out_q <= spare_q;
    end else if (q_pop_o) begin
      out_q   <= q_job_i.t0;
      spare_q <= q_job_i.t1;
    end
  end

endmodule

FILE: design/c_lexer_token_scanner.sv
`timescale 1ns / 1ps
// Path: a token passes through the job queue and then the output register to the master side.
// Throughput: one byte per cycle while the queue is not full; the output register sends one
// token per cycle while m_axis_tready is high, so the two tokens of one byte (held identifier
// or slash plus its own) leave in turn, absorbed by the four-entry job queue between stages.
// Reset: rst_ni clears scan mode, position, queue and output valid asynchronously.

module c_lexer_token_scanner #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [3:0] token_kind, [27:4] token_start,
                                      // [51:28] token_length, [55:52] zero
  output logic        m_axis_tlast    // last_of_run
);
  import c_lex_pkg::*;

  logic   push, full, q_valid, q_pop;
  job_t   push_job, head_job;
  token_t out_tok;

  c_lex_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .data_i     (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  c_lex_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  c_lex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok)
  );

  assign m_axis_tdata = {4'b0000, out_tok.length, out_tok.start, out_tok.kind};
  assign m_axis_tlast = out_tok.last;

endmodule
